[rtl/tit_pkg.sv]
// Shared types and constants for the trickle interval timer.
package tit_pkg;

  localparam int IV_W     = 32;          // interval, fire time and elapsed width
  localparam int DIV_W    = IV_W + 1;    // span I - I/2 + 1, computed one bit wider than IV_W
  localparam int MAXS_W   = IV_W + 32;   // imin << doublings before saturation
  localparam int RND_W    = 16;
  localparam int IMIN_W   = 16;
  localparam int DBL_W    = 5;
  localparam int CNT_W    = 8;
  localparam int OUTIV_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int STEP_W   = $clog2(RND_W + 1);

  localparam logic [STEP_W-1:0] MOD_STEPS = STEP_W'(RND_W);
  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_IMIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLINGS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K         = 2'd2;

  localparam logic [IMIN_W-1:0] IMIN_RST = 16'd1000;
  localparam logic [DBL_W-1:0]  DBL_RST  = 5'd3;
  localparam logic [CNT_W-1:0]  K_RST    = 8'd10;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_HEARD  = 3'd3,
    OP_RESET  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_FINISH
  } state_t;

endpackage

[rtl/tit_mod_unit.sv]
// Bit-serial remainder unit: random value modulo interval span.
module tit_mod_unit
  import tit_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             busy,
  output logic [RND_W-1:0] remainder
);

  logic [STEP_W-1:0] steps;
  logic [RND_W-1:0]  rem;
  logic [RND_W-1:0]  rem_next;
  logic [RND_W-1:0]  dvd;
  logic [DIV_W-1:0]  divisor_r;
  logic [RND_W:0]    trial;
  logic [DIV_W-1:0]  trial_ext;
  logic [DIV_W-1:0]  diff;

  // remainder stays below the divisor, so one subtract per step suffices
  always_comb begin
    trial     = {rem, dvd[RND_W-1]};
    trial_ext = DIV_W'(trial);
    diff      = trial_ext - divisor_r;
    if (trial_ext >= divisor_r) begin
      rem_next = diff[RND_W-1:0];
    end else begin
      rem_next = trial[RND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= MOD_STEPS;
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem       <= '0;
      dvd       <= dividend;
      divisor_r <= divisor;
    end else if (steps != '0) begin
      rem <= rem_next;
      dvd <= {dvd[RND_W-2:0], 1'b0};
    end
  end

  assign busy      = (steps != '0);
  assign remainder = rem;

endmodule

[rtl/trickle_interval_timer_core.sv]
// Trickle interval timer: sequencer, timer state and result register.
//
// Input channel (in_valid / in_stall) carries one operation per transfer:
// tick, start, stop, consistent heard or reset, plus a 16-bit random value.
// Every accepted item yields exactly one result on the output channel
// (out_valid / out_stall): transmit, interval_end, accepted, running and
// the current interval length.
// in_stall is high from acceptance until the result is loaded into the
// output register; one item is worked on at a time.
// An accepted item goes through EXEC and then FINISH, where the result is
// loaded; items that begin an interval (start, reset, interval expiry) also
// pass through MOD, which waits for the 16 one-bit steps of the remainder unit.
// A held result does not block the next transfer in; the sequencer waits
// only when a new result is ready and the previous one is still stalled.
// Reset (rst, synchronous) stops the timer, clears all timer state and restores
// imin 1000, doublings 3, k 10. The config port writes a register on any cycle
// with cfg_write high; imin and doublings apply at the next interval, k at once.
module trickle_interval_timer_core
  import tit_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           operation,
  input  logic [RND_W-1:0]     random_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 transmit,
  output logic                 interval_end,
  output logic                 accepted,
  output logic                 running,
  output logic [OUTIV_W-1:0]   interval_now
);

  state_t state, state_next;

  logic [IMIN_W-1:0] imin;
  logic [DBL_W-1:0]  doublings;
  logic [CNT_W-1:0]  redundancy_k;

  logic              is_running;
  logic [IV_W-1:0]   interval_len;
  logic [IV_W-1:0]   fire_time;
  logic [IV_W-1:0]   elapsed_ticks;
  logic [CNT_W-1:0]  consistent_count;
  logic [IV_W-1:0]   half;

  op_t               op;
  logic [RND_W-1:0]  rnd;
  logic              tx_r, iend_r, acc_r;

  // exec controls
  logic              do_accept, do_tx, do_iend, do_begin, do_tick;
  logic              run_set, run_clr, cnt_inc;
  logic [IV_W-1:0]   new_len;
  logic              load_out;

  // arithmetic for the exec step
  logic [IV_W-1:0]   elapsed_inc;
  logic [IV_W-1:0]   target;
  logic [MAXS_W-1:0] max_wide;
  logic [IV_W-1:0]   max_len;
  logic [IV_W:0]     dbl_wide;
  logic [IV_W-1:0]   dbl_len;
  logic [IV_W-1:0]   grown_len;
  logic [IV_W-1:0]   imin_len;
  logic [DIV_W-1:0]  span;

  logic              mod_start;
  logic              mod_busy;
  logic [RND_W-1:0]  mod_rem;

  always_comb begin
    elapsed_inc = elapsed_ticks + 1'b1;
    target      = (fire_time == '0) ? IV_W'(1) : fire_time;
    max_wide    = MAXS_W'(imin) << doublings;
    max_len     = (max_wide[MAXS_W-1:IV_W] != '0) ? {IV_W{1'b1}} : max_wide[IV_W-1:0];
    dbl_wide    = {interval_len, 1'b0};
    dbl_len     = dbl_wide[IV_W] ? {IV_W{1'b1}} : dbl_wide[IV_W-1:0];
    grown_len   = (dbl_len > max_len) ? max_len : dbl_len;
    imin_len    = IV_W'(imin);
    span        = {1'b0, new_len} - {2'b0, new_len[IV_W-1:1]} + 1'b1;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_EXEC;
      ST_EXEC:   state_next = do_begin ? ST_MOD : ST_FINISH;
      ST_MOD:    if (!mod_busy) state_next = ST_FINISH;
      ST_FINISH: if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    do_accept = 1'b0;
    do_tx     = 1'b0;
    do_iend   = 1'b0;
    do_begin  = 1'b0;
    do_tick   = 1'b0;
    run_set   = 1'b0;
    run_clr   = 1'b0;
    cnt_inc   = 1'b0;
    new_len   = imin_len;
    if (state == ST_EXEC) begin
      case (op)
        OP_TICK: begin
          if (is_running) begin
            do_accept = 1'b1;
            do_tick   = 1'b1;
            do_tx     = (elapsed_inc == target) && (consistent_count < redundancy_k);
            if (elapsed_inc >= interval_len) begin
              do_iend  = 1'b1;
              do_begin = 1'b1;
              new_len  = grown_len;
            end
          end
        end
        OP_START: begin
          do_accept = 1'b1;
          run_set   = 1'b1;
          do_begin  = 1'b1;
        end
        OP_STOP: begin
          if (is_running) begin
            do_accept = 1'b1;
            run_clr   = 1'b1;
          end
        end
        OP_HEARD: begin
          do_accept = 1'b1;
          cnt_inc   = 1'b1;
        end
        OP_RESET: begin
          if (is_running) begin
            do_accept = 1'b1;
            do_begin  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign mod_start = do_begin;
  assign load_out  = (state == ST_FINISH) && (!out_valid || !out_stall);
  assign in_stall  = (state != ST_IDLE);

  tit_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (rnd),
    .divisor   (span),
    .busy      (mod_busy),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      imin         <= IMIN_RST;
      doublings    <= DBL_RST;
      redundancy_k <= K_RST;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_IMIN:      imin         <= cfg_data[IMIN_W-1:0];
          REG_DOUBLINGS: doublings    <= cfg_data[DBL_W-1:0];
          REG_K:         redundancy_k <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      is_running       <= 1'b0;
      interval_len     <= '0;
      fire_time        <= '0;
      elapsed_ticks    <= '0;
      consistent_count <= '0;
    end else begin
      if (run_set) begin
        is_running <= 1'b1;
      end else if (run_clr) begin
        is_running <= 1'b0;
      end
      if (do_tick) begin
        elapsed_ticks <= elapsed_inc;
      end
      if (cnt_inc && consistent_count != CNT_MAX) begin
        consistent_count <= consistent_count + 1'b1;
      end
      if (do_begin) begin
        interval_len <= new_len;
      end
      // interval begins once the remainder is ready
      if (state == ST_MOD && !mod_busy) begin
        fire_time        <= half + IV_W'(mod_rem);
        elapsed_ticks    <= '0;
        consistent_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op  <= op_t'(operation);
      rnd <= random_value;
    end
    if (state == ST_EXEC) begin
      tx_r   <= do_tx;
      iend_r <= do_iend;
      acc_r  <= do_accept;
      half   <= {1'b0, new_len[IV_W-1:1]};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      transmit     <= tx_r;
      interval_end <= iend_r;
      accepted     <= acc_r;
      running      <= is_running;
      interval_now <= OUTIV_W'(interval_len);
    end
  end

endmodule

[tb/sv/tit_checker.sv]
// Checker for the trickle interval timer: mirrors its registers and state, predicts and compares.
module tit_checker
  import tit_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [2:0]           operation,
  input  logic [RND_W-1:0]     random_value,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 transmit,
  input  logic                 interval_end,
  input  logic                 accepted,
  input  logic                 running,
  input  logic [OUTIV_W-1:0]   interval_now,
  output int                   fail_count,
  output int                   outstanding
);

  typedef struct packed {
    logic               transmit;
    logic               interval_end;
    logic               accepted;
    logic               running;
    logic [OUTIV_W-1:0] interval_now;
  } timer_result_t;

  localparam logic [63:0] IV_MAX = 64'hFFFF_FFFF;

  logic [IMIN_W-1:0] imin_reg;
  logic [DBL_W-1:0]  dbl_reg;
  logic [CNT_W-1:0]  k_reg;

  logic              timer_on;
  logic [63:0]       cur_len;
  logic [63:0]       fire_at;
  logic [63:0]       ticks_in;
  logic [CNT_W-1:0]  heard_cnt;

  timer_result_t     expected_q[$];
  int                mismatches = 0;
  int                n_results = 0;

  assign fail_count = mismatches;

  // largest interval allowed: imin << doublings, saturated to the interval width
  function automatic logic [63:0] interval_cap();
    logic [63:0] v;
    v = 64'(imin_reg) << dbl_reg;
    return (v > IV_MAX) ? IV_MAX : v;
  endfunction

  function automatic void open_interval(logic [RND_W-1:0] rnd);
    logic [63:0] half;
    logic [63:0] span;
    half = cur_len / 2;
    span = cur_len - half + 1;
    heard_cnt = '0;
    ticks_in = '0;
    fire_at = (half + (64'(rnd) % span)) & IV_MAX;
  endfunction

  function automatic timer_result_t step_timer(logic [2:0] op, logic [RND_W-1:0] rnd);
    timer_result_t r;
    logic [63:0]   target;
    logic [63:0]   grown;
    r = '0;
    case (op)
      OP_TICK: begin
        if (timer_on) begin
          // a fire time of zero is hit on the first tick
          target = (fire_at == 0) ? 64'd1 : fire_at;
          r.accepted = 1'b1;
          ticks_in = (ticks_in + 1) & IV_MAX;
          // transmit check uses the count of the interval that is ending
          if (ticks_in == target && heard_cnt < k_reg) r.transmit = 1'b1;
          if (ticks_in >= cur_len) begin
            grown = cur_len * 2;
            if (grown > IV_MAX) grown = IV_MAX;
            if (grown > interval_cap()) grown = interval_cap();
            cur_len = grown;
            r.interval_end = 1'b1;
            open_interval(rnd);
          end
        end
      end
      OP_START: begin
        r.accepted = 1'b1;
        timer_on = 1'b1;
        cur_len = 64'(imin_reg);
        open_interval(rnd);
      end
      OP_STOP: begin
        if (timer_on) begin
          r.accepted = 1'b1;
          timer_on = 1'b0;
        end
      end
      OP_HEARD: begin
        r.accepted = 1'b1;
        if (heard_cnt != CNT_MAX) heard_cnt++;
      end
      OP_RESET: begin
        if (timer_on) begin
          r.accepted = 1'b1;
          cur_len = 64'(imin_reg);
          open_interval(rnd);
        end
      end
      default: begin
      end
    endcase
    r.running = timer_on;
    r.interval_now = cur_len[OUTIV_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $time, n_results, what, got, want);
  endtask

  always @(posedge clk) begin : monitor
    timer_result_t want;
    if (rst) begin
      imin_reg = IMIN_RST;
      dbl_reg = DBL_RST;
      k_reg = K_RST;
      timer_on = 1'b0;
      cur_len = '0;
      fire_at = '0;
      ticks_in = '0;
      heard_cnt = '0;
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMIN:      imin_reg = cfg_data[IMIN_W-1:0];
          REG_DOUBLINGS: dbl_reg = cfg_data[DBL_W-1:0];
          REG_K:         k_reg = cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected, interval_now",
                          64'(interval_now), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (transmit !== want.transmit)
            report_mismatch("transmit", 64'(transmit), 64'(want.transmit));
          if (interval_end !== want.interval_end)
            report_mismatch("interval_end", 64'(interval_end), 64'(want.interval_end));
          if (accepted !== want.accepted)
            report_mismatch("accepted", 64'(accepted), 64'(want.accepted));
          if (running !== want.running)
            report_mismatch("running", 64'(running), 64'(want.running));
          if (interval_now !== want.interval_now)
            report_mismatch("interval_now", 64'(interval_now), 64'(want.interval_now));
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(step_timer(operation, random_value));
    end
    outstanding = expected_q.size();
  end

endmodule

[tb/sv/tb_trickle_interval_timer_core.sv]
// Testbench top for the trickle interval timer: clock, reset, stimulus, back-pressure, verdict.
module tb_trickle_interval_timer_core;
  import tit_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 70;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 150;
  localparam int TAIL_CYCLES  = 40;

  // operation codes the block must ignore
  localparam logic [2:0] OP_UNUSED_FIRST = 3'(OP_RESET) + 3'd1;
  localparam logic [2:0] OP_UNUSED_MID   = 3'(OP_RESET) + 3'd2;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [2:0]           operation;
  logic [RND_W-1:0]     random_value;
  logic                 out_valid;
  logic                 out_stall;
  logic                 transmit;
  logic                 interval_end;
  logic                 accepted;
  logic                 running;
  logic [OUTIV_W-1:0]   interval_now;

  int fail_count;
  int outstanding;
  int cycles = 0;
  int results_seen = 0;
  int burst_left = 0;

  trickle_interval_timer_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .random_value (random_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .transmit     (transmit),
    .interval_end (interval_end),
    .accepted     (accepted),
    .running      (running),
    .interval_now (interval_now)
  );

  tit_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .random_value (random_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .transmit     (transmit),
    .interval_end (interval_end),
    .accepted     (accepted),
    .running      (running),
    .interval_now (interval_now),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("trickle_interval_timer_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) results_seen <= results_seen + 1;
  end

  // result side: one long hold-off once traffic is flowing, otherwise changing stall patterns
  initial begin : result_side
    int mode;
    int span;
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        @(negedge clk);
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (int n = 0; n < span; n++) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = 1'($urandom_range(0, 1));
          2: out_stall = ($urandom_range(0, 7) != 0);
          default: out_stall = (n % 3 == 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // unused upper data bits are randomized; only the register width matters
  task automatic set_timer(logic [IMIN_W-1:0] imin_v, logic [DBL_W-1:0] dbl_v,
                           logic [CNT_W-1:0] k_v);
    write_reg(REG_IMIN, imin_v);
    write_reg(REG_DOUBLINGS, {11'($urandom), dbl_v});
    write_reg(REG_K, {8'($urandom), k_v});
  endtask

  // offers one item; bursts of random length separated by random gaps
  task automatic send(logic [2:0] op, logic [RND_W-1:0] rnd);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    operation = op;
    random_value = rnd;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pauses until every expected result has been seen
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic logic [RND_W-1:0] pick_rnd();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return RND_W'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_op();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 62) return OP_TICK;
    if (roll < 76) return OP_HEARD;
    if (roll < 83) return OP_START;
    if (roll < 89) return OP_RESET;
    if (roll < 94) return OP_STOP;
    return 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
  endfunction

  initial begin : stimulus
    logic [IMIN_W-1:0] imin_v;
    logic [DBL_W-1:0]  dbl_v;
    logic [CNT_W-1:0]  k_v;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_TICK;
    random_value = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // stopped timer: ticks, stop, reset and unused codes are ignored, heard still counts
    send(OP_TICK, '1);
    send(OP_STOP, '0);
    send(OP_RESET, 16'h8000);
    send(OP_HEARD, '0);
    send(OP_UNUSED_FIRST, '1);
    send(OP_UNUSED_MID, 16'h5555);
    send(OP_UNUSED_LAST, 16'hAAAA);
    // default registers, restart while running, reset and stop
    send(OP_START, '0);
    send(OP_START, '1);
    send(OP_HEARD, 16'h1234);
    send(OP_RESET, 16'h8000);
    send(OP_TICK, '0);
    send(OP_STOP, '1);
    send(OP_TICK, '1);
    settle();

    // zero imin: fire time zero, every tick closes the interval
    set_timer('0, '0, '0);
    send(OP_START, '1);
    send(OP_TICK, '0);
    send(OP_TICK, '1);
    settle();

    // transmit and interval end on one tick, largest doublings value
    set_timer(16'd1, '1, '1);
    send(OP_START, 16'd1);
    repeat (4) send(OP_TICK, pick_rnd());
    settle();

    // widest imin: cap saturates at the interval width
    set_timer('1, '1, '0);
    send(OP_START, '1);
    send(OP_TICK, '0);
    send(OP_HEARD, '1);
    send(OP_TICK, '1);
    settle();

    // heard counter saturation
    set_timer(16'd3, 5'd2, '1);
    send(OP_START, pick_rnd());
    repeat (260) send(OP_HEARD, pick_rnd());
    repeat (30) send(OP_TICK, pick_rnd());
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin imin_v = 16'd1; dbl_v = 5'd0;  k_v = 8'd0;   end
        1: begin imin_v = 16'd0; dbl_v = 5'd5;  k_v = 8'd3;   end
        2: begin imin_v = 16'd2; dbl_v = 5'd16; k_v = 8'd255; end
        3: begin imin_v = 16'd3; dbl_v = 5'd3;  k_v = 8'd1;   end
        4: begin imin_v = 16'd5; dbl_v = 5'd31; k_v = 8'd2;   end
        5: begin imin_v = 16'd4; dbl_v = 5'd2;  k_v = 8'd255; end
        6: begin imin_v = 16'd6; dbl_v = 5'd1;  k_v = 8'd0;   end
        default: begin
          imin_v = IMIN_W'($urandom_range(1, 9));
          dbl_v = DBL_W'($urandom_range(0, 31));
          k_v = ($urandom_range(0, 1) == 0) ? CNT_W'($urandom_range(0, 4)) : CNT_W'($urandom);
        end
      endcase
      set_timer(imin_v, dbl_v, k_v);
      send(OP_START, pick_rnd());
      repeat (PHASE_ITEMS) send(pick_op(), pick_rnd());
      settle();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("trickle_interval_timer_core regression: pass");
    end else begin
      $display("trickle_interval_timer_core regression: fail");
    end
    $finish;
  end

endmodule
